[hdl/fre_pkg.sv]
package fre_pkg;

    localparam int SCREEN_WIDTH  = 84;
    localparam int SCREEN_HEIGHT = 48;
    localparam int STORE_ROWS    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * STORE_ROWS;
    localparam int ADDR_W        = $clog2(STORE_BYTES);

    localparam logic [2:0] ACT_PIXEL  = 3'd0;
    localparam logic [2:0] ACT_LINE   = 3'd1;
    localparam logic [2:0] ACT_RECT   = 3'd2;
    localparam logic [2:0] ACT_CIRCLE = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;
    localparam logic [2:0] ACT_INVERT = 3'd5;
    localparam logic [2:0] ACT_READ   = 3'd6;

    // pixel write request from the drawing sequencer to the store port
    typedef struct packed {
        logic               valid;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic               ink;
    } t_pix_req;

endpackage

[hdl/fre_store.sv]
// Frame store with pixel read-modify-write. A taken request is read, then
// modified and written back before the next is taken. Also does whole-store
// sweeps (fill, invert) and single byte reads.
module fre_store
    import fre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pix_req          i_pix,
    output logic              o_pix_ready,
    input  logic              i_sweep_start,
    input  logic              i_sweep_inv,
    input  logic              i_sweep_ink,
    input  logic              i_rd_start,
    input  logic [8:0]        i_rd_index,
    output logic              o_busy,
    output logic [7:0]        o_rd_data
);

    typedef enum logic [2:0] {S_IDLE, S_PIX_WR, S_CLR, S_INV_RD, S_INV_WR, S_RD}
        t_state;

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_q;
    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic [2:0]        r_bit;
    logic              r_ink;
    logic              r_sv_ink;
    logic [7:0]        r_rd_data;

    logic              n_we;
    logic [ADDR_W-1:0] n_waddr;
    logic [7:0]        n_wdata;
    logic [ADDR_W-1:0] n_raddr;
    logic              pix_on;
    logic [ADDR_W-1:0] pix_addr;
    logic [7:0]        pix_mask;

    // clipping and address of the requested pixel
    always_comb begin
        pix_on   = (i_pix.x >= 0) && (i_pix.x < SCREEN_WIDTH) &&
                   (i_pix.y >= 0) && (i_pix.y < SCREEN_HEIGHT);
        pix_addr = ADDR_W'(i_pix.x[8:0]) +
                   ADDR_W'(ADDR_W'(i_pix.y[8:3]) * ADDR_W'(SCREEN_WIDTH));
        pix_mask = 8'd1 << r_bit;
    end

    assign o_pix_ready = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_rd_data   = r_rd_data;

    // write and read port selection
    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_addr;
        n_wdata = 8'd0;
        n_raddr = pix_addr;
        case (r_state)
            S_PIX_WR: begin
                n_we    = 1'b1;
                n_wdata = r_ink ? (r_q | pix_mask) : (r_q & ~pix_mask);
            end
            S_CLR: begin
                n_we    = 1'b1;
                n_wdata = r_sv_ink ? 8'hFF : 8'h00;
            end
            S_INV_WR: begin
                n_we    = 1'b1;
                n_wdata = ~r_q;
            end
            default: n_raddr = pix_addr;
        endcase
        if (r_state == S_IDLE && i_sweep_start) n_raddr = '0;
        // keep the byte under inversion on the read port
        if (r_state == S_INV_RD) n_raddr = r_addr;
        if (r_state == S_INV_WR) n_raddr = r_addr + 1'b1;
        if (r_state == S_IDLE && i_rd_start) n_raddr = ADDR_W'(i_rd_index);
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        r_q <= r_mem[n_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
            r_sv_ink <= 1'b0;
            r_rd_data <= 8'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_sweep_start) begin
                        r_addr   <= '0;
                        r_sv_ink <= i_sweep_ink;
                        r_state  <= i_sweep_inv ? S_INV_RD : S_CLR;
                    end else if (i_rd_start) begin
                        r_addr  <= ADDR_W'(i_rd_index);
                        r_state <= S_RD;
                    end else if (i_pix.valid && pix_on) begin
                        r_addr  <= pix_addr;
                        r_bit   <= i_pix.y[2:0];
                        r_ink   <= i_pix.ink;
                        r_state <= S_PIX_WR;
                    end
                end
                S_PIX_WR: r_state <= S_IDLE;
                S_CLR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(STORE_BYTES - 1)) r_state <= S_IDLE;
                end
                S_INV_RD: r_state <= S_INV_WR;
                S_INV_WR: begin
                    r_addr <= r_addr + 1'b1;
                    r_state <= (r_addr == ADDR_W'(STORE_BYTES - 1)) ? S_IDLE : S_INV_RD;
                end
                S_RD: begin
                    r_rd_data <= r_q;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/framebuffer_raster_engine.sv]
// Raster engine for a monochrome framebuffer of 84 x 48 pixels held as
// 504 bytes in one synchronous memory, each byte covering eight pixels
// stacked vertically. One command word is taken at a time and one result
// word (the read byte, else zero) is given per command. Every drawn pixel
// costs a read-modify-write on the single memory port (an off-screen
// pixel is skipped without one). A line writes its first pixel twice.
// After reset the store is cleared before the first command is taken.
module framebuffer_raster_engine
    import fre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_action,
    input  logic signed [8:0] i_start_x,
    input  logic signed [8:0] i_start_y,
    input  logic signed [8:0] i_end_x,
    input  logic signed [8:0] i_end_y,
    input  logic [6:0]        i_radius,
    input  logic [6:0]        i_thickness,
    input  logic              i_filled,
    input  logic              i_ink_black,
    input  logic [8:0]        i_byte_index,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_read_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_LINE_INIT, S_LINE, S_RECT_NEXT, S_CIRC_INIT, S_CIRC_AX,
        S_CIRC_STEP, S_CIRC_PTS, S_WAIT, S_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_act;
    logic               r_fill, r_ink, r_is_rd;
    logic signed [11:0] r_sx, r_sy, r_ex, r_ey;
    // line engine
    logic signed [11:0] r_lx, r_ly, r_lxb, r_lyb, r_dx, r_dy, r_err;
    logic               r_lsx, r_lsy, r_xmaj;
    // rectangle
    logic [2:0]         r_rseg;
    logic signed [11:0] r_rcx;
    // circle
    logic signed [11:0] r_rad, r_cx, r_cy, r_f, r_ddx, r_ddy;
    logic [6:0]         r_pass;
    logic [2:0]         r_pt;
    // output
    logic               r_ovalid;
    logic [7:0]         r_odata;

    t_pix_req           pix;
    logic               pix_ready, st_busy, sweep_go, rd_go;
    logic [7:0]         rd_data;
    logic signed [11:0] lx_nx, ly_nx;

    fre_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix),
        .o_pix_ready  (pix_ready),
        .i_sweep_start(sweep_go),
        .i_sweep_inv  (i_action == ACT_INVERT),
        .i_sweep_ink  (i_ink_black),
        .i_rd_start   (rd_go),
        .i_rd_index   (i_byte_index),
        .o_busy       (st_busy),
        .o_rd_data    (rd_data)
    );

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid && !st_busy;
    assign o_valid     = r_ovalid;
    assign o_read_data = r_odata;

    wire take = i_valid && o_ready;
    assign sweep_go = take && (i_action == ACT_CLEAR || i_action == ACT_INVERT);
    assign rd_go    = take && (i_action == ACT_READ) &&
                      (i_byte_index < 9'(STORE_BYTES));

    // pixel request mux
    always_comb begin
        pix.valid = 1'b0;
        pix.x     = r_lx;
        pix.y     = r_ly;
        pix.ink   = r_ink;
        case (r_state)
            S_LINE: pix.valid = 1'b1;
            S_CIRC_AX: begin
                pix.valid = 1'b1;
                case (r_pt)
                    3'd0: begin pix.x = r_cx;         pix.y = r_cy + r_rad; end
                    3'd1: begin pix.x = r_cx;         pix.y = r_cy - r_rad; end
                    3'd2: begin pix.x = r_cx + r_rad; pix.y = r_cy; end
                    default: begin pix.x = r_cx - r_rad; pix.y = r_cy; end
                endcase
            end
            S_CIRC_PTS: begin
                pix.valid = 1'b1;
                case (r_pt)
                    3'd0: begin pix.x = r_cx + r_lx; pix.y = r_cy + r_ly; end
                    3'd1: begin pix.x = r_cx - r_lx; pix.y = r_cy + r_ly; end
                    3'd2: begin pix.x = r_cx + r_lx; pix.y = r_cy - r_ly; end
                    3'd3: begin pix.x = r_cx - r_lx; pix.y = r_cy - r_ly; end
                    3'd4: begin pix.x = r_cx + r_ly; pix.y = r_cy + r_lx; end
                    3'd5: begin pix.x = r_cx - r_ly; pix.y = r_cy + r_lx; end
                    3'd6: begin pix.x = r_cx + r_ly; pix.y = r_cy - r_lx; end
                    default: begin pix.x = r_cx - r_ly; pix.y = r_cy - r_lx; end
                endcase
            end
            default: pix.valid = 1'b0;
        endcase
    end

    assign lx_nx = r_lsx ? r_lx - 12'sd1 : r_lx + 12'sd1;
    assign ly_nx = r_lsy ? r_ly - 12'sd1 : r_ly + 12'sd1;

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_odata  <= 8'd0;
            r_pt     <= 3'd0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_act  <= i_action;
                        r_ink  <= i_ink_black;
                        r_fill <= i_filled;
                        r_is_rd <= rd_go;
                        r_sx <= 12'(i_start_x); r_sy <= 12'(i_start_y);
                        r_ex <= 12'(i_end_x);   r_ey <= 12'(i_end_y);
                        r_lx <= 12'(i_start_x); r_ly <= 12'(i_start_y);
                        r_lxb <= 12'(i_end_x);  r_lyb <= 12'(i_end_y);
                        r_rseg <= 3'd0;
                        r_rcx  <= 12'(i_start_x);
                        r_cx <= 12'(i_start_x); r_cy <= 12'(i_start_y);
                        r_rad <= 12'(i_radius);
                        r_pass <= i_thickness;
                        case (i_action)
                            ACT_PIXEL: begin
                                r_lx <= 12'(i_start_x); r_ly <= 12'(i_start_y);
                                r_lxb <= 12'(i_start_x); r_lyb <= 12'(i_start_y);
                                r_state <= S_LINE_INIT;
                            end
                            ACT_LINE: r_state <= S_LINE_INIT;
                            ACT_RECT: r_state <= S_RECT_NEXT;
                            ACT_CIRCLE: r_state <= S_CIRC_INIT;
                            default: r_state <= S_WAIT;
                        endcase
                    end
                end
                S_LINE_INIT: begin
                    r_lsx <= r_lxb < r_lx;
                    r_lsy <= r_lyb < r_ly;
                    r_dx  <= ((r_lxb < r_lx) ? r_lx - r_lxb : r_lxb - r_lx) <<< 1;
                    r_dy  <= ((r_lyb < r_ly) ? r_ly - r_lyb : r_lyb - r_ly) <<< 1;
                    r_state <= S_LINE;
                end
                S_LINE: begin
                    // first pixel: set up error term
                    if (pix_ready) begin
                        if (r_pt == 3'd0) begin
                            r_xmaj <= r_dx > r_dy;
                            r_err  <= (r_dx > r_dy) ? r_dy - (r_dx >>> 1)
                                                    : r_dx - (r_dy >>> 1);
                            r_pt   <= 3'd1;
                            if ((r_dx > r_dy) ? (r_lx == r_lxb) : (r_ly == r_lyb)) begin
                                r_pt <= 3'd0;
                                r_state <= (r_act == ACT_RECT) ? S_RECT_NEXT : S_WAIT;
                            end
                        end else begin
                            if (r_xmaj) begin
                                if (r_err >= 0) begin
                                    r_ly  <= ly_nx;
                                    r_err <= r_err - r_dx + r_dy;
                                end else r_err <= r_err + r_dy;
                                r_lx <= lx_nx;
                                if (lx_nx == r_lxb) r_pt <= 3'd2;
                            end else begin
                                if (r_err >= 0) begin
                                    r_lx  <= lx_nx;
                                    r_err <= r_err - r_dy + r_dx;
                                end else r_err <= r_err + r_dx;
                                r_ly <= ly_nx;
                                if (ly_nx == r_lyb) r_pt <= 3'd2;
                            end
                            if (r_pt == 3'd2) begin
                                r_pt <= 3'd0;
                                r_state <= (r_act == ACT_RECT) ? S_RECT_NEXT : S_WAIT;
                            end
                        end
                    end
                end
                S_RECT_NEXT: begin
                    r_state <= S_LINE_INIT;
                    r_ly  <= r_sy;
                    r_lyb <= r_ey;
                    if (r_fill) begin
                        // vertical lines toward end_x, end column excluded
                        if (r_rcx == r_ex) r_state <= S_WAIT;
                        else begin
                            r_lx  <= r_rcx;
                            r_lxb <= r_rcx;
                            r_rcx <= (r_rcx > r_ex) ? r_rcx - 12'sd1 : r_rcx + 12'sd1;
                        end
                    end else begin
                        r_rseg <= r_rseg + 3'd1;
                        case (r_rseg)
                            3'd0: begin r_lx <= r_sx; r_lxb <= r_ex; r_lyb <= r_sy; end
                            3'd1: begin r_lx <= r_sx; r_lxb <= r_ex;
                                        r_ly <= r_ey; end
                            3'd2: begin r_lx <= r_sx; r_lxb <= r_sx; end
                            3'd3: begin r_lx <= r_ex; r_lxb <= r_ex; end
                            default: r_state <= S_WAIT;
                        endcase
                    end
                end
                S_CIRC_INIT: begin
                    if (r_pass == 7'd0) r_state <= S_WAIT;
                    else begin
                        r_f   <= 12'sd1 - r_rad;
                        r_ddx <= 12'sd0;
                        r_ddy <= -(r_rad <<< 1);
                        r_lx  <= 12'sd0;
                        r_ly  <= r_rad;
                        r_pt  <= 3'd0;
                        r_state <= S_CIRC_AX;
                    end
                end
                S_CIRC_AX: begin
                    if (pix_ready) begin
                        r_pt <= r_pt + 3'd1;
                        if (r_pt == 3'd3) begin
                            r_pt <= 3'd0;
                            r_state <= S_CIRC_STEP;
                        end
                    end
                end
                S_CIRC_STEP: begin
                    if (r_lx < r_ly) begin
                        if (r_f >= 0) begin
                            r_ly  <= r_ly - 12'sd1;
                            r_ddy <= r_ddy + 12'sd2;
                            r_f   <= r_f + r_ddy + 12'sd2 + r_ddx + 12'sd3;
                        end else r_f <= r_f + r_ddx + 12'sd3;
                        r_ddx <= r_ddx + 12'sd2;
                        r_lx  <= r_lx + 12'sd1;
                        r_state <= S_CIRC_PTS;
                    end else begin
                        r_rad  <= r_rad - 12'sd1;
                        r_pass <= r_pass - 7'd1;
                        r_state <= S_CIRC_INIT;
                    end
                end
                S_CIRC_PTS: begin
                    if (pix_ready) begin
                        r_pt <= r_pt + 3'd1;
                        if (r_pt == 3'd7) r_state <= S_CIRC_STEP;
                    end
                end
                S_WAIT: begin
                    if (pix_ready && !st_busy) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!st_busy) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_is_rd ? rd_data : 8'd0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hdl/fre_checker.sv]
module fre_props
    import fre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic [2:0] i_action,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [7:0] o_read_data
);

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data))
        else $error("result word changed while stalled");

    // no new command while a result waits
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("command taken with result pending");

    // accepted command gives no result in the very next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("result too early");

    // non-read commands return zero, checked at one fixed sample after acceptance
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_action != ACT_READ |=> ##1 !o_valid || o_read_data == 8'd0)
        else $error("non-read command returned data");

endmodule

bind framebuffer_raster_engine fre_props u_fre_props (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_action   (i_action),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_read_data(o_read_data)
);
